// ===== rtl/core/mwee_pkg.sv =====
`default_nettype none

package mwee_pkg;

    // Widths of the fixed item fields.
    localparam int KIND_W    = 3;
    localparam int ADDR_IN_W = 8;
    localparam int WORD_IN_W = 16;
    localparam int STATUS_W  = 2;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [ADDR_IN_W-1:0] addr_in_t;
    typedef logic [WORD_IN_W-1:0] word_in_t;

    // Item kinds. Codes six and seven behave as a tick.
    localparam kind_t KIND_TICK    = 3'd0;
    localparam kind_t KIND_READ    = 3'd1;
    localparam kind_t KIND_WRITE   = 3'd2;
    localparam kind_t KIND_WREN    = 3'd3;
    localparam kind_t KIND_WRDIS   = 3'd4;
    localparam kind_t KIND_ERAL    = 3'd5;

    // Result status codes.
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_REJECT  = 2'd1;
    localparam status_t STAT_NO_ZERO = 2'd2;

    // Two-bit opcodes sent after the start bit.
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_EXT   = 2'b00;

    // Top two address bits that select an extended command.
    localparam logic [1:0] EXT_WREN  = 2'b11;
    localparam logic [1:0] EXT_ERAL  = 2'b10;
    localparam logic [1:0] EXT_WRDIS = 2'b00;

endpackage

`default_nettype wire

// ===== rtl/core/microwire_eeprom_master_unit.sv =====
// Bit-slot master for a 93C66-style three-wire serial EEPROM in word mode.
// The input channel (s_valid/s_ready) carries one word per slot: a command
// word (read, write, write enable, write disable, erase all) loads a frame
// of start bit, opcode, address and, for a write, data, all sent MSB first;
// a tick word advances the bus by one bit slot and carries the sampled
// level of the EEPROM data-out pin. Each accepted word yields exactly one
// result word on the output channel (m_valid/m_ready) with the pin levels
// for that slot, busy and done flags, read data and a status code.
// A command that arrives while a sequence is running is rejected with
// status 1 and leaves the sequence untouched.
// The result of an accepted word is registered and offered in the cycle
// after it is accepted. The sequencer state and the result register are
// updated by one level of logic, so a new word is taken every cycle while
// the receiver keeps m_ready high; s_ready is high whenever the result
// register is empty or is being emptied in the same cycle.
// When the receiver stalls, the pending result is held and s_ready drops
// until it is taken. A synchronous active-low reset returns the sequencer
// to idle and empties the result register; no clearing pass is needed.
`default_nettype none

module microwire_eeprom_master_unit #(
    parameter int ADDR_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  mwee_pkg::kind_t  s_kind,
    input  wire  mwee_pkg::addr_in_t s_word_address,
    input  wire  mwee_pkg::word_in_t s_write_word,
    input  wire                    s_serial_out_level,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_select_level,
    output logic                   m_serial_in_level,
    output logic                   m_clock_pulse,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output mwee_pkg::word_in_t     m_read_word,
    output mwee_pkg::status_t      m_status
);

    import mwee_pkg::*;

    // The frame is kept left-justified, so the next bit is always the MSB.
    localparam int FRAME_W   = 3 + ADDR_BITS + WORD_BITS;
    localparam int CNT_W     = $clog2(FRAME_W + 1);
    localparam int SHORT_LEN = 3 + ADDR_BITS;
    localparam int LONG_LEN  = FRAME_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_CHECK,
        PH_READ,
        PH_DESEL,
        PH_POLL
    } phase_t;

    phase_t               phase_reg,  phase_next;
    logic [FRAME_W-1:0]   frame_reg,  frame_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [WORD_BITS-1:0] rshift_reg, rshift_next;
    kind_t                op_reg,     op_next;

    logic     m_valid_reg;
    logic     sel_reg,  sel_next;
    logic     din_reg,  din_next;
    logic     clk_reg,  clk_next;
    logic     busy_reg, busy_next;
    logic     done_reg, done_next;
    word_in_t rword_reg, rword_next;
    status_t  stat_reg, stat_next;

    logic                 accept;
    logic                 is_cmd;
    logic [ADDR_BITS-1:0] addr_field;
    logic [WORD_BITS-1:0] data_field;
    logic [ADDR_BITS-1:0] cmd_field;
    logic [1:0]           opcode;
    logic [CNT_W-1:0]     count_dec;
    logic [WORD_BITS-1:0] rshift_in;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_cmd     = s_kind inside {KIND_READ, KIND_WRITE, KIND_WREN, KIND_WRDIS, KIND_ERAL};
    assign addr_field = ADDR_BITS'(s_word_address);
    assign data_field = WORD_BITS'(s_write_word);
    assign count_dec  = count_reg - CNT_W'(1);
    assign rshift_in  = {rshift_reg[WORD_BITS-2:0], s_serial_out_level};

    // Opcode and address field of the frame for each command.
    always_comb begin
        opcode    = OPC_EXT;
        cmd_field = addr_field;
        case (s_kind)
            KIND_READ: begin
                opcode = OPC_READ;
            end
            KIND_WRITE: begin
                opcode = OPC_WRITE;
            end
            KIND_WREN: begin
                cmd_field = {EXT_WREN, (ADDR_BITS - 2)'(0)};
            end
            KIND_ERAL: begin
                cmd_field = {EXT_ERAL, (ADDR_BITS - 2)'(0)};
            end
            default: begin
                cmd_field = {EXT_WRDIS, (ADDR_BITS - 2)'(0)};
            end
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        frame_next  = frame_reg;
        count_next  = count_reg;
        rshift_next = rshift_reg;
        op_next     = op_reg;
        sel_next    = 1'b0;
        din_next    = 1'b0;
        clk_next    = 1'b0;
        busy_next   = 1'b0;
        done_next   = 1'b0;
        rword_next  = '0;
        stat_next   = STAT_OK;

        if (is_cmd && phase_reg != PH_IDLE) begin
            // Rejected: report the live select level and change nothing.
            sel_next  = (phase_reg != PH_DESEL);
            busy_next = 1'b1;
            stat_next = STAT_REJECT;
        end else if (is_cmd) begin
            if (s_kind == KIND_WRITE) begin
                frame_next = {1'b1, opcode, cmd_field, data_field};
                count_next = CNT_W'(LONG_LEN);
            end else begin
                frame_next = {1'b1, opcode, cmd_field, WORD_BITS'(0)};
                count_next = CNT_W'(SHORT_LEN);
            end
            op_next     = s_kind;
            rshift_next = '0;
            phase_next  = PH_SEND;
            sel_next    = 1'b1;
            busy_next   = 1'b1;
        end else begin
            case (phase_reg)
                PH_SEND: begin
                    sel_next   = 1'b1;
                    din_next   = frame_reg[FRAME_W-1];
                    clk_next   = 1'b1;
                    busy_next  = 1'b1;
                    frame_next = {frame_reg[FRAME_W-2:0], 1'b0};
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        if (op_reg == KIND_READ) begin
                            phase_next = PH_CHECK;
                        end else if (op_reg == KIND_WRITE || op_reg == KIND_ERAL) begin
                            phase_next = PH_DESEL;
                        end else begin
                            phase_next = PH_IDLE;
                            busy_next  = 1'b0;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_CHECK: begin
                    sel_next = 1'b1;
                    if (!s_serial_out_level) begin
                        phase_next  = PH_READ;
                        count_next  = CNT_W'(WORD_BITS);
                        rshift_next = '0;
                        busy_next   = 1'b1;
                    end else begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                        stat_next  = STAT_NO_ZERO;
                    end
                end
                PH_READ: begin
                    sel_next    = 1'b1;
                    clk_next    = 1'b1;
                    busy_next   = 1'b1;
                    rshift_next = rshift_in;
                    count_next  = count_dec;
                    if (count_dec == '0) begin
                        phase_next = PH_IDLE;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                        rword_next = WORD_IN_W'(rshift_in);
                    end
                end
                PH_DESEL: begin
                    // Select stays low for one slot to start the self-timed cycle.
                    phase_next = PH_POLL;
                    busy_next  = 1'b1;
                end
                PH_POLL: begin
                    sel_next = 1'b1;
                    if (!s_serial_out_level) begin
                        clk_next  = 1'b1;
                        busy_next = 1'b1;
                    end else begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            op_reg      <= KIND_TICK;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                op_reg      <= op_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            frame_reg  <= frame_next;
            rshift_reg <= rshift_next;
            sel_reg    <= sel_next;
            din_reg    <= din_next;
            clk_reg    <= clk_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            rword_reg  <= rword_next;
            stat_reg   <= stat_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_select_level    = sel_reg;
    assign m_serial_in_level = din_reg;
    assign m_clock_pulse     = clk_reg;
    assign m_busy_res        = busy_reg;
    assign m_done_res        = done_reg;
    assign m_read_word       = rword_reg;
    assign m_status          = stat_reg;

`ifndef SYNTHESIS
    // A finishing slot never also reports the sequence as still running.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_busy_res))
        else $error("done and busy both set");

    // A serial clock pulse is only issued with the chip selected.
    a_clock_needs_select: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clock_pulse |-> m_select_level)
        else $error("clock pulse without select");

    // Read data appears only on a successful finishing slot.
    a_read_word_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_word != '0 |-> m_done_res && m_status == STAT_OK)
        else $error("read data outside a finished read");

    // A rejected command reports busy and does not clock the bus.
    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_REJECT |-> m_busy_res && !m_clock_pulse)
        else $error("malformed reject result");

    // A command taken while idle starts sending its frame.
    a_cmd_starts_send: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_cmd && phase_reg == PH_IDLE |=> phase_reg == PH_SEND)
        else $error("command did not start a frame");
`endif

endmodule

`default_nettype wire
